>>> rtl/qenc_pkg.sv
// Shared types, constants and helpers of the quadrature position counter.
// No dependencies; qenc_cfg, qenc_core and the top level refer to it by scoped names.
`default_nettype none

package qenc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int COUNT_BITS   = 32;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int MASK_W       = 4;
    localparam logic [MASK_W-1:0] REVERSE_MASK_RESET = 4'd10;

    // word index of each register
    localparam logic REG_REVERSE_MASK = 1'b0;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_SEED   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] channel;
        logic       level_a;
        logic       level_b;
    } item_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic [2:0]         out_channel;
    } result_t;

    // step per transition, indexed by {old phase, new phase}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
        2'sd0,  2'sd1,  -2'sd1, 2'sd0,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        2'sd0,  -2'sd1, 2'sd1,  2'sd0
    };

    function automatic logic signed [31:0] to_position(input logic [COUNT_BITS-1:0] cnt);
        return 32'($signed(cnt));
    endfunction

endpackage

`default_nettype wire

>>> rtl/qenc_if.sv
// Valid/ready channel interfaces for requests and results.
// No dependencies; the payload widths are written out as literals.
`default_nettype none

interface qenc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] channel;
    logic       level_a;
    logic       level_b;

    modport source (output valid, kind, channel, level_a, level_b, input ready);
    modport sink   (input valid, kind, channel, level_a, level_b, output ready);
endinterface

interface qenc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic [2:0]         out_channel;

    modport source (output valid, position, out_channel, input ready);
    modport sink   (input valid, position, out_channel, output ready);
endinterface

`default_nettype wire

>>> rtl/qenc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qenc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                         clk,
    input  wire                         we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]             wdata,
    input  wire                         re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/qenc_cfg.sv
// APB register block holding the per-channel direction reverse mask.
// Depends on qenc_pkg.
`default_nettype none

module qenc_cfg (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [qenc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [qenc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [qenc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [qenc_pkg::MASK_W-1:0]         reverse_mask
);

    logic                            mask_sel;
    logic [qenc_pkg::MASK_W-1:0]     mask_reg;
    logic [qenc_pkg::MASK_W-1:0]     mask_next;

    // registers sit on 4-byte boundaries; byte-lane bits are ignored
    assign mask_sel = (paddr[2] == qenc_pkg::REG_REVERSE_MASK);

    always_comb
    begin
        mask_next = mask_reg;
        if (psel && penable && pwrite && mask_sel)
        begin
            mask_next = pwdata[qenc_pkg::MASK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= qenc_pkg::REVERSE_MASK_RESET;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign pready       = 1'b1;
    assign prdata       = mask_sel ? qenc_pkg::APB_DATA_W'(mask_reg) : '0;
    assign reverse_mask = mask_reg;

endmodule

`default_nettype wire

>>> rtl/qenc_core.sv
// Read-modify-write core: count and phase memories, one execute stage,
// write bypass and clear-by-valid-bits. Depends on qenc_pkg and qenc_ram.
`default_nettype none

module qenc_core (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_fire,
    input  qenc_pkg::item_t                 in_item,
    input  wire [qenc_pkg::MASK_W-1:0]      reverse_mask,
    input  wire                             s1_adv,
    output logic                            s1_valid,
    output qenc_pkg::result_t               s1_result
);

    localparam int NCH = qenc_pkg::NUM_CHANNELS;
    localparam int CW  = qenc_pkg::CH_W;
    localparam int CB  = qenc_pkg::COUNT_BITS;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    qenc_pkg::item_t        s1_item_reg;

    logic [NCH-1:0]         cnt_vld_reg;
    logic [NCH-1:0]         cnt_vld_next;
    logic [NCH-1:0]         ph_vld_reg;
    logic [NCH-1:0]         ph_vld_next;

    logic                   cnt_byp_vld_reg;
    logic                   cnt_byp_vld_next;
    logic [CW-1:0]          cnt_byp_ch_reg;
    logic [CB-1:0]          cnt_byp_reg;
    logic                   ph_byp_vld_reg;
    logic                   ph_byp_vld_next;
    logic [CW-1:0]          ph_byp_ch_reg;
    logic [1:0]             ph_byp_reg;

    logic [CB-1:0]          cnt_rdata;
    logic [1:0]             ph_rdata;

    logic                   s1_fire;
    logic                   in_range;
    logic [CW-1:0]          idx;
    logic [1:0]             ph_new;
    logic [1:0]             ph_old;
    logic [CB-1:0]          cnt_old;
    logic [CB-1:0]          cnt_new;
    logic signed [1:0]      step;
    logic [15:0]            rev_vec;
    logic                   rev;
    logic                   cnt_we;
    logic                   ph_we;
    logic                   do_clear;
    logic [CW-1:0]          in_idx;

    assign in_idx   = CW'(in_item.channel);
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign idx      = CW'(s1_item_reg.channel);
    assign in_range = (32'(s1_item_reg.channel) < NCH);
    assign ph_new   = {s1_item_reg.level_a, s1_item_reg.level_b};

    qenc_ram #(.WIDTH(CB), .DEPTH(NCH)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (idx),
        .wdata (cnt_new),
        .re    (in_fire),
        .raddr (in_idx),
        .rdata (cnt_rdata)
    );

    qenc_ram #(.WIDTH(2), .DEPTH(NCH)) u_ph_ram (
        .clk   (clk),
        .we    (ph_we),
        .waddr (idx),
        .wdata (ph_new),
        .re    (in_fire),
        .raddr (in_idx),
        .rdata (ph_rdata)
    );

    // forward the write retired on the edge that launched this read;
    // entries never written read as zero, and a clear zeroes every count but no phase
    always_comb
    begin
        if (!ph_vld_reg[idx])
        begin
            ph_old = 2'b00;
        end
        else if (ph_byp_vld_reg && (ph_byp_ch_reg == idx))
        begin
            ph_old = ph_byp_reg;
        end
        else
        begin
            ph_old = ph_rdata;
        end

        if (!cnt_vld_reg[idx])
        begin
            cnt_old = '0;
        end
        else if (cnt_byp_vld_reg && (cnt_byp_ch_reg == idx))
        begin
            cnt_old = cnt_byp_reg;
        end
        else
        begin
            cnt_old = cnt_rdata;
        end
    end

    assign rev_vec = 16'(reverse_mask);
    assign rev     = rev_vec[4'(idx)];
    assign step    = qenc_pkg::STEP_TABLE[{ph_old, ph_new}];

    always_comb
    begin
        cnt_new = cnt_old;
        if (step != 2'sd0)
        begin
            // positive step with reverse or negative without: count down
            if ((step == 2'sd1) != rev)
            begin
                cnt_new = cnt_old + CB'(1);
            end
            else
            begin
                cnt_new = cnt_old - CB'(1);
            end
        end
    end

    always_comb
    begin
        cnt_we   = 1'b0;
        ph_we    = 1'b0;
        do_clear = 1'b0;
        s1_result.out_channel = s1_item_reg.channel;
        s1_result.position    = '0;
        case (s1_item_reg.kind)
            qenc_pkg::KIND_SAMPLE:
            begin
                cnt_we = s1_fire && in_range;
                ph_we  = s1_fire && in_range;
                if (in_range)
                begin
                    s1_result.position = qenc_pkg::to_position(cnt_new);
                end
            end
            qenc_pkg::KIND_SEED:
            begin
                ph_we = s1_fire && in_range;
                if (in_range)
                begin
                    s1_result.position = qenc_pkg::to_position(cnt_old);
                end
            end
            qenc_pkg::KIND_READ:
            begin
                if (in_range)
                begin
                    s1_result.position = qenc_pkg::to_position(cnt_old);
                end
            end
            qenc_pkg::KIND_CLEAR:
            begin
                do_clear = s1_fire;
            end
            default:
            begin
                s1_result.position = '0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        cnt_vld_next     = cnt_vld_reg;
        cnt_byp_vld_next = cnt_byp_vld_reg;
        ph_vld_next      = ph_vld_reg;
        ph_byp_vld_next  = ph_byp_vld_reg;
        if (do_clear)
        begin
            cnt_vld_next     = '0;
            cnt_byp_vld_next = 1'b0;
        end
        if (cnt_we)
        begin
            cnt_vld_next[idx] = 1'b1;
            cnt_byp_vld_next  = 1'b1;
        end
        if (ph_we)
        begin
            ph_vld_next[idx] = 1'b1;
            ph_byp_vld_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            cnt_vld_reg     <= '0;
            ph_vld_reg      <= '0;
            cnt_byp_vld_reg <= 1'b0;
            ph_byp_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            cnt_vld_reg     <= cnt_vld_next;
            ph_vld_reg      <= ph_vld_next;
            cnt_byp_vld_reg <= cnt_byp_vld_next;
            ph_byp_vld_reg  <= ph_byp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (cnt_we)
        begin
            cnt_byp_ch_reg <= idx;
            cnt_byp_reg    <= cnt_new;
        end
        if (ph_we)
        begin
            ph_byp_ch_reg <= idx;
            ph_byp_reg    <= ph_new;
        end
    end

    assign s1_valid = s1_valid_reg;

endmodule

`default_nettype wire

>>> rtl/quad_encoder_counter_x4_unit.sv
// Four-channel x4 quadrature position counter, top level.
// Each request is read from memory into the execute stage, then registered at the output.
// Throughput: one request per cycle while out_ch is not stalled; the count memory
// read-modify-write has a one-entry bypass for back-to-back requests on the same channel.
// Reset: rst_n clears all counts and phases (valid bits), reverse_mask to 4'b1010; no sweep.
// Depends on qenc_pkg, qenc_if, qenc_ram, qenc_cfg, qenc_core.
`default_nettype none

module quad_encoder_counter_x4_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [qenc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [qenc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [qenc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    qenc_req_if.sink                            in_ch,
    qenc_res_if.source                          out_ch
);

    logic [qenc_pkg::MASK_W-1:0]    reverse_mask;
    qenc_pkg::item_t                in_item;
    qenc_pkg::result_t              s1_result;
    logic                           s1_valid;
    logic                           s1_adv;
    logic                           in_fire;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    qenc_pkg::result_t              out_res_reg;

    qenc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .reverse_mask (reverse_mask)
    );

    assign in_item.kind    = qenc_pkg::kind_t'(in_ch.kind);
    assign in_item.channel = in_ch.channel;
    assign in_item.level_a = in_ch.level_a;
    assign in_item.level_b = in_ch.level_b;

    // advance the execute stage whenever the output register frees up
    assign s1_adv      = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !s1_valid || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    qenc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .in_item      (in_item),
        .reverse_mask (reverse_mask),
        .s1_adv       (s1_adv),
        .s1_valid     (s1_valid),
        .s1_result    (s1_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid)
        begin
            out_res_reg <= s1_result;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.position    = out_res_reg.position;
    assign out_ch.out_channel = out_res_reg.out_channel;

endmodule

`default_nettype wire
